/* hdl/bol_pkg.sv */
`default_nettype none

package bol_pkg;

    // fixed port widths
    localparam int CMD_W     = 4;
    localparam int POS_W     = 9;
    localparam int PORT_EW   = 32;
    localparam int COUNT_W   = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REPL_LAST = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REPL_AT   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_RESIZE    = 4'd8;

    // per-cell operations broadcast along the chain
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // fan-in of each level of the read-out tree
    localparam int GATHER_FAN = 16;

    typedef struct packed {
        logic [1:0] op;
        logic       sel_en;
    } t_cell_ctl;

    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_gat_ctl;

endpackage

`default_nettype wire

/* hdl/bounded_ordered_list_top.sv */
// Bounded ordered list: up to DEPTH entry words kept in a row of cells.
// Input channel i_valid/o_ready carries one command word (cmd, position,
// entry, new capacity); output channel o_valid/i_ready carries one result
// word (ok, entry, count, full, empty) per command.
// An accepted command moves through the execute state, where the cells all
// shift at once and the first tree level loads, then the second level of
// the read-out tree (two registered levels of 16-way ORs), then the output
// register. A new command is taken only once the last one has left the tree.
// o_ready is high while no command is in flight. A result waiting in the
// output register does not block the next command; that command finishes
// its work and holds in the last tree stage until the output is taken.
// Reset (synchronous, i_rst_n low) empties the list and sets the capacity
// to DEPTH; entry storage is not cleared, as only held entries are read.
`default_nettype none

module bounded_ordered_list_top #(
    parameter int DEPTH      = 256,
    parameter int ENTRY_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [bol_pkg::CMD_W-1:0]     i_cmd,
    input  wire  [bol_pkg::POS_W-1:0]     i_position,
    input  wire  [bol_pkg::PORT_EW-1:0]   i_entry_in,
    input  wire  [bol_pkg::POS_W-1:0]     i_new_capacity,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_ok,
    output logic [bol_pkg::PORT_EW-1:0]   o_entry_out,
    output logic [bol_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_full,
    output logic                          o_is_empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W;
    localparam int KW   = (ENTRY_BITS < bol_pkg::PORT_EW) ? ENTRY_BITS : bol_pkg::PORT_EW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_G1   = 2'd2;
    localparam logic [1:0] S_G2   = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [bol_pkg::CMD_W-1:0]   r_cmd;
    logic [CMPW-1:0]             r_pos;
    logic [CMPW-1:0]             r_ncap;
    logic [ENTRY_BITS-1:0]       r_word;
    logic [CW-1:0]               r_held, n_held;
    logic [CW-1:0]               r_cap, n_cap;
    logic                        r_ok, n_ok;
    logic                        r_use_word, n_use_word;
    logic                        r_out_valid, n_out_valid;
    logic                        r_o_ok;
    logic [bol_pkg::PORT_EW-1:0] r_o_entry;
    logic [bol_pkg::COUNT_W-1:0] r_o_count;
    logic                        r_o_full;
    logic                        r_o_empty;

    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_load_out;
    logic [CMPW-1:0]             w_held;
    logic [CMPW-1:0]             w_cap;
    logic [CMPW-1:0]             w_idx;
    logic                        w_full;
    logic [1:0]                  w_op;
    logic                        w_sel;
    bol_pkg::t_cell_ctl          w_ctl;
    bol_pkg::t_gat_ctl           w_gctl;
    logic [ENTRY_BITS-1:0]       w_gat;
    logic [ENTRY_BITS-1:0]       w_data [DEPTH];
    logic [ENTRY_BITS-1:0]       w_tap  [DEPTH];

    assign w_in_acc   = i_valid && o_ready;
    assign w_out_acc  = r_out_valid && i_ready;
    assign w_load_out = (r_state == S_G2) && (!r_out_valid || i_ready);

    assign w_held = CMPW'(r_held);
    assign w_cap  = CMPW'(r_cap);
    assign w_full = w_held >= w_cap;

    // command decode, used in the execute cycle only
    always_comb begin
        n_ok       = 1'b0;
        n_use_word = 1'b0;
        n_held     = r_held;
        n_cap      = r_cap;
        w_op       = bol_pkg::OP_HOLD;
        w_sel      = 1'b0;
        w_idx      = r_pos;
        case (r_cmd)
            bol_pkg::CMD_APPEND: begin
                n_ok       = !w_full;
                n_use_word = 1'b1;
                w_op       = bol_pkg::OP_WRITE;
                w_idx      = w_held;
                n_held     = CW'(w_held + CMPW'(1));
            end
            bol_pkg::CMD_INSERT: begin
                n_ok       = !w_full && (r_pos <= w_held);
                n_use_word = 1'b1;
                w_op       = bol_pkg::OP_INSERT;
                n_held     = CW'(w_held + CMPW'(1));
            end
            bol_pkg::CMD_POP: begin
                n_ok   = r_held != '0;
                w_sel  = 1'b1;
                w_idx  = w_held - CMPW'(1);
                n_held = CW'(w_held - CMPW'(1));
            end
            bol_pkg::CMD_REMOVE: begin
                n_ok   = r_pos < w_held;
                w_sel  = 1'b1;
                w_op   = bol_pkg::OP_REMOVE;
                n_held = CW'(w_held - CMPW'(1));
            end
            bol_pkg::CMD_REPL_LAST: begin
                n_ok       = r_held != '0;
                n_use_word = 1'b1;
                w_op       = bol_pkg::OP_WRITE;
                w_idx      = w_held - CMPW'(1);
            end
            bol_pkg::CMD_REPL_AT: begin
                n_ok       = r_pos < w_held;
                n_use_word = 1'b1;
                w_op       = bol_pkg::OP_WRITE;
            end
            bol_pkg::CMD_READ: begin
                n_ok  = r_pos < w_held;
                w_sel = 1'b1;
            end
            bol_pkg::CMD_CLEAR: begin
                n_ok   = 1'b1;
                n_held = '0;
            end
            bol_pkg::CMD_RESIZE: begin
                n_ok  = (r_ncap != '0) && (r_ncap <= CMPW'(DEPTH));
                n_cap = CW'(r_ncap);
                if (w_held > r_ncap) n_held = CW'(r_ncap);
            end
            default: begin
            end
        endcase
        if (!n_ok) begin
            n_held = r_held;
            n_cap  = r_cap;
        end
    end

    assign w_ctl.op     = ((r_state == S_EXEC) && n_ok) ? w_op : bol_pkg::OP_HOLD;
    assign w_ctl.sel_en = (r_state == S_EXEC) && n_ok && w_sel;
    assign w_gctl.ld1   = r_state == S_EXEC;
    assign w_gctl.ld2   = r_state == S_G1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_EXEC;
            S_EXEC:  n_state = S_G1;
            S_G1:    n_state = S_G2;
            S_G2:    if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_acc) n_out_valid = 1'b0;
        if (w_load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_cap       <= CW'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_EXEC) begin
                r_held <= n_held;
                r_cap  <= n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= i_cmd;
            r_pos  <= CMPW'(i_position);
            r_ncap <= CMPW'(i_new_capacity);
            r_word <= ENTRY_BITS'(i_entry_in[KW-1:0]);
        end
        if (r_state == S_EXEC) begin
            r_ok       <= n_ok;
            r_use_word <= n_use_word;
        end
        if (w_load_out) begin
            r_o_ok    <= r_ok;
            r_o_entry <= !r_ok ? '0 :
                         r_use_word ? bol_pkg::PORT_EW'(r_word[KW-1:0]) :
                                      bol_pkg::PORT_EW'(w_gat[KW-1:0]);
            r_o_count <= bol_pkg::COUNT_W'(r_held);
            r_o_full  <= r_held >= r_cap;
            r_o_empty <= r_held == '0;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [ENTRY_BITS-1:0] w_left;
        logic [ENTRY_BITS-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        bol_cell #(
            .EW    (ENTRY_BITS),
            .AW    (AW),
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (w_idx[AW-1:0]),
            .i_word  (r_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    bol_gather #(
        .EW    (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_gather (
        .i_clk  (i_clk),
        .i_ctl  (w_gctl),
        .i_tap  (w_tap),
        .o_data (w_gat)
    );

    assign o_ready     = r_state == S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_ok        = r_o_ok;
    assign o_entry_out = r_o_entry;
    assign o_count     = r_o_count;
    assign o_is_full   = r_o_full;
    assign o_is_empty  = r_o_empty;

endmodule

`default_nettype wire

/* hdl/bol_cell.sv */
`default_nettype none

module bol_cell #(
    parameter int EW    = 32,
    parameter int AW    = 8,
    parameter int INDEX = 0
) (
    input  wire                   i_clk,
    input  bol_pkg::t_cell_ctl    i_ctl,
    input  wire  [AW-1:0]         i_idx,
    input  wire  [EW-1:0]         i_word,
    input  wire  [EW-1:0]         i_left,
    input  wire  [EW-1:0]         i_right,
    output logic [EW-1:0]         o_data,
    output logic [EW-1:0]         o_tap
);

    localparam logic [AW-1:0] MY_IDX = AW'(INDEX);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            bol_pkg::OP_WRITE: begin
                if (MY_IDX == i_idx) n_data = i_word;
            end
            bol_pkg::OP_INSERT: begin
                if (MY_IDX > i_idx) n_data = i_left;
                else if (MY_IDX == i_idx) n_data = i_word;
            end
            bol_pkg::OP_REMOVE: begin
                if (MY_IDX >= i_idx) n_data = i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // old word, before any shift of this cycle
    assign o_tap  = (i_ctl.sel_en && (MY_IDX == i_idx)) ? r_data : '0;

endmodule

`default_nettype wire

/* hdl/bol_gather.sv */
`default_nettype none

module bol_gather #(
    parameter int EW    = 32,
    parameter int DEPTH = 256
) (
    input  wire                 i_clk,
    input  bol_pkg::t_gat_ctl   i_ctl,
    input  wire  [EW-1:0]       i_tap [DEPTH],
    output logic [EW-1:0]       o_data
);

    localparam int FAN = bol_pkg::GATHER_FAN;
    localparam int NG1 = (DEPTH + FAN - 1) / FAN;
    localparam int NG2 = (NG1 + FAN - 1) / FAN;

    logic [EW-1:0] r_g1 [NG1];
    logic [EW-1:0] n_g1 [NG1];
    logic [EW-1:0] r_g2 [NG2];
    logic [EW-1:0] n_g2 [NG2];

    // at most one tap is non-zero, so OR acts as the select
    always_comb begin
        for (int g = 0; g < NG1; g++) begin
            n_g1[g] = '0;
            for (int k = 0; k < FAN; k++) begin
                if (g * FAN + k < DEPTH) n_g1[g] = n_g1[g] | i_tap[g * FAN + k];
            end
        end
        for (int g = 0; g < NG2; g++) begin
            n_g2[g] = '0;
            for (int k = 0; k < FAN; k++) begin
                if (g * FAN + k < NG1) n_g2[g] = n_g2[g] | r_g1[g * FAN + k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) r_g1 <= n_g1;
        if (i_ctl.ld2) r_g2 <= n_g2;
    end

    always_comb begin
        o_data = '0;
        for (int g = 0; g < NG2; g++) o_data = o_data | r_g2[g];
    end

endmodule

`default_nettype wire

/* hdl/bol_chk.sv */
`default_nettype none

module bol_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_ready,
    input wire                         o_valid,
    input wire                         i_ready,
    input wire                         o_ok,
    input wire [bol_pkg::PORT_EW-1:0]  o_entry_out,
    input wire [bol_pkg::COUNT_W-1:0]  o_count,
    input wire                         o_is_full,
    input wire                         o_is_empty
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_out) && $stable(o_count))
        else $error("result word changed while stalled");

    // one command in flight: ready drops after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after accepting a command");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_entry_out == '0)
        else $error("refused command returned an entry");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_is_empty == (o_count == '0))
        else $error("empty flag disagrees with count");

    // capacity is never zero, so full and empty exclude each other
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_full && o_is_empty))
        else $error("full and empty both set");

endmodule

bind bounded_ordered_list_top bol_chk u_chk (.*);

`default_nettype wire

/* tb/bounded_ordered_list_checker.sv */
module bounded_ordered_list_checker #(
    parameter int DEPTH      = 256,
    parameter int ENTRY_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cmd_valid,
    input  wire                           i_cmd_ready,
    input  wire [bol_pkg::CMD_W-1:0]      i_cmd,
    input  wire [bol_pkg::POS_W-1:0]      i_position,
    input  wire [bol_pkg::PORT_EW-1:0]    i_entry_in,
    input  wire [bol_pkg::POS_W-1:0]      i_new_capacity,
    input  wire                           i_res_valid,
    input  wire                           i_res_ready,
    input  wire                           i_ok,
    input  wire [bol_pkg::PORT_EW-1:0]    i_entry_out,
    input  wire [bol_pkg::COUNT_W-1:0]    i_count,
    input  wire                           i_is_full,
    input  wire                           i_is_empty,
    output int                            o_fail_count,
    output int                            o_pending,
    output int unsigned                   o_words_in,
    output int unsigned                   o_list_len
);

    localparam int CMD_W   = bol_pkg::CMD_W;
    localparam int PORT_EW = bol_pkg::PORT_EW;
    localparam int COUNT_W = bol_pkg::COUNT_W;

    localparam logic [63:0] KEEP_MASK =
        (ENTRY_BITS >= 64) ? '1 : ((64'd1 << ENTRY_BITS) - 64'd1);

    typedef struct packed {
        logic               ok;
        logic [PORT_EW-1:0] entry;
        logic [COUNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_list_result;

    logic [PORT_EW-1:0] slots [DEPTH];
    int unsigned        held;
    int unsigned        cap;
    t_list_result       result_q [$];

    // carries out one command on the list copy and returns the result word
    function automatic t_list_result apply_cmd(input logic [CMD_W-1:0] cmd,
                                               input int unsigned pos,
                                               input logic [PORT_EW-1:0] raw,
                                               input int unsigned ncap);
        t_list_result       r;
        logic               full;
        logic [PORT_EW-1:0] word;
        int unsigned        k;
        r    = '0;
        word = raw & KEEP_MASK[PORT_EW-1:0];
        full = (held >= cap) || (held >= DEPTH);
        case (cmd)
            bol_pkg::CMD_APPEND: if (!full) begin
                slots[held] = word;
                held++;
                r.ok    = 1'b1;
                r.entry = word;
            end
            bol_pkg::CMD_INSERT: if (!full && pos <= held) begin
                for (k = held; k > pos; k--)
                    slots[k] = slots[k-1];
                slots[pos] = word;
                held++;
                r.ok    = 1'b1;
                r.entry = word;
            end
            bol_pkg::CMD_POP: if (held > 0) begin
                held--;
                r.ok    = 1'b1;
                r.entry = slots[held];
            end
            bol_pkg::CMD_REMOVE: if (pos < held) begin
                r.ok    = 1'b1;
                r.entry = slots[pos];
                for (k = pos; k + 1 < held; k++)
                    slots[k] = slots[k+1];
                held--;
            end
            bol_pkg::CMD_REPL_LAST: if (held > 0) begin
                slots[held-1] = word;
                r.ok    = 1'b1;
                r.entry = word;
            end
            bol_pkg::CMD_REPL_AT: if (pos < held) begin
                slots[pos] = word;
                r.ok    = 1'b1;
                r.entry = word;
            end
            bol_pkg::CMD_READ: if (pos < held) begin
                r.ok    = 1'b1;
                r.entry = slots[pos];
            end
            bol_pkg::CMD_CLEAR: begin
                held = 0;
                r.ok = 1'b1;
            end
            bol_pkg::CMD_RESIZE: if (ncap != 0 && ncap <= DEPTH) begin
                cap = ncap;
                if (held > ncap)
                    held = ncap;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = COUNT_W'(held);
        r.full  = held >= cap;
        r.empty = held == 0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [PORT_EW-1:0] want,
                               input logic [PORT_EW-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            held = 0;
            cap  = DEPTH;
            result_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with none expected");
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("ok", want.ok, i_ok);
                    check_field("entry_out", want.entry, i_entry_out);
                    check_field("count", want.count, i_count);
                    check_field("is_full", want.full, i_is_full);
                    check_field("is_empty", want.empty, i_is_empty);
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                result_q = {result_q,
                            apply_cmd(i_cmd, i_position, i_entry_in, i_new_capacity)};
                o_words_in++;
            end
        end
        o_pending  = result_q.size();
        o_list_len = held;
    end

endmodule

/* tb/bounded_ordered_list_top_tb.sv */
module bounded_ordered_list_top_tb;

    localparam int CMD_W       = bol_pkg::CMD_W;
    localparam int POS_W       = bol_pkg::POS_W;
    localparam int PORT_EW     = bol_pkg::PORT_EW;
    localparam int COUNT_W     = bol_pkg::COUNT_W;
    localparam int DEPTH       = 256;
    localparam int ENTRY_BITS  = 32;
    localparam int PHASE_WORDS = 380;
    localparam int POS_MAX     = (1 << POS_W) - 1;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_LAST_CODE = '1;
    localparam t_cmd CMD_UNUSED    = t_cmd'(bol_pkg::CMD_RESIZE + 1);

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic [CMD_W-1:0]   i_cmd          = '0;
    logic [POS_W-1:0]   i_position     = '0;
    logic [PORT_EW-1:0] i_entry_in     = '0;
    logic [POS_W-1:0]   i_new_capacity = '0;
    logic               i_ready        = 1'b0;

    wire                o_ready;
    wire                o_valid;
    wire                o_ok;
    wire [PORT_EW-1:0]  o_entry_out;
    wire [COUNT_W-1:0]  o_count;
    wire                o_is_full;
    wire                o_is_empty;

    int                 fail_count;
    int                 pending;
    int unsigned        words_in;
    int unsigned        list_len;

    int                 tx_idle_pct  = 0;
    int                 rx_stall_pct = 0;
    int                 words_sent   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_ordered_list_top #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_entry_in     (i_entry_in),
        .i_new_capacity (i_new_capacity),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_ok           (o_ok),
        .o_entry_out    (o_entry_out),
        .o_count        (o_count),
        .o_is_full      (o_is_full),
        .o_is_empty     (o_is_empty)
    );

    bounded_ordered_list_checker #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_ready    (o_ready),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_entry_in     (i_entry_in),
        .i_new_capacity (i_new_capacity),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_ok           (o_ok),
        .i_entry_out    (o_entry_out),
        .i_count        (o_count),
        .i_is_full      (o_is_full),
        .i_is_empty     (o_is_empty),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_words_in     (words_in),
        .o_list_len     (list_len)
    );

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= rx_stall_pct);

    // called at a falling edge; returns at the falling edge after the word is taken,
    // leaving valid high so a back-to-back word needs no drop
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                             input logic [PORT_EW-1:0] word, input int unsigned ncap);
        int unsigned seen;
        seen = words_in;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_position     <= POS_W'(pos);
        i_entry_in     <= word;
        i_new_capacity <= POS_W'(ncap);
        do @(negedge i_clk); while (words_in == seen);
        words_sent++;
    endtask

    function automatic logic [PORT_EW-1:0] random_word();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        return $urandom;
    endfunction

    // mostly inside the list or on its end, now and then anywhere
    function automatic int unsigned pick_pos();
        if ($urandom_range(99) < 85)
            return $urandom_range(list_len);
        return $urandom_range(POS_MAX);
    endfunction

    function automatic int unsigned pick_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(12, 1);
        else if (r < 75)
            return $urandom_range(DEPTH - 1, 13);
        else if (r < 88)
            return DEPTH;
        else if (r < 94)
            return 0;
        return $urandom_range(POS_MAX, DEPTH + 1);
    endfunction

    task automatic run_episode();
        int unsigned n;
        int          r;
        issue_cmd(bol_pkg::CMD_RESIZE, pick_pos(), random_word(), pick_capacity());
        n = $urandom_range(40, 8);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 24)
                issue_cmd(bol_pkg::CMD_APPEND, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 38)
                issue_cmd(bol_pkg::CMD_INSERT, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 48)
                issue_cmd(bol_pkg::CMD_POP, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 60)
                issue_cmd(bol_pkg::CMD_REMOVE, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 66)
                issue_cmd(bol_pkg::CMD_REPL_LAST, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 74)
                issue_cmd(bol_pkg::CMD_REPL_AT, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 88)
                issue_cmd(bol_pkg::CMD_READ, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 90)
                issue_cmd(bol_pkg::CMD_CLEAR, pick_pos(), random_word(),
                          $urandom_range(POS_MAX));
            else if (r < 94)
                issue_cmd(bol_pkg::CMD_RESIZE, pick_pos(), random_word(), pick_capacity());
            else if (r < 97)
                issue_cmd(t_cmd'($urandom_range(CMD_LAST_CODE, CMD_UNUSED)), pick_pos(),
                          random_word(), $urandom_range(POS_MAX));
            else
                issue_cmd(t_cmd'($urandom_range(CMD_LAST_CODE)), $urandom_range(POS_MAX),
                          $urandom, $urandom_range(POS_MAX));
        end
    endtask

    // whole store: fill to DEPTH, shift the full chain both ways, then shrink hard
    task automatic fill_store();
        issue_cmd(bol_pkg::CMD_CLEAR, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_RESIZE, 0, '0, DEPTH);
        repeat (DEPTH - 1)
            issue_cmd(bol_pkg::CMD_APPEND, 0, random_word(), 0);
        issue_cmd(bol_pkg::CMD_INSERT, 0, random_word(), 0);
        issue_cmd(bol_pkg::CMD_APPEND, 0, random_word(), 0);
        issue_cmd(bol_pkg::CMD_REMOVE, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_INSERT, DEPTH - 1, random_word(), 0);
        issue_cmd(bol_pkg::CMD_READ, DEPTH - 1, '0, 0);
        issue_cmd(bol_pkg::CMD_POP, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_RESIZE, 0, '0, 1);
    endtask

    initial begin
        int base;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list: everything that needs an entry is refused
        issue_cmd(bol_pkg::CMD_POP, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_REMOVE, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_REPL_LAST, 0, 32'hDEAD_BEEF, 0);
        issue_cmd(bol_pkg::CMD_REPL_AT, 0, 32'hDEAD_BEEF, 0);
        issue_cmd(bol_pkg::CMD_READ, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_APPEND, 0, '1, 0);
        issue_cmd(bol_pkg::CMD_APPEND, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_INSERT, 0, 32'hA5A5_5A5A, 0);
        issue_cmd(bol_pkg::CMD_INSERT, 3, 32'h1234_5678, 0);    // position == count appends
        issue_cmd(bol_pkg::CMD_INSERT, 5, 32'h0BAD_0BAD, 0);    // beyond count
        issue_cmd(bol_pkg::CMD_READ, 3, '0, 0);
        issue_cmd(bol_pkg::CMD_READ, 4, '0, 0);
        issue_cmd(bol_pkg::CMD_REPL_AT, 1, 32'h5555_AAAA, 0);
        issue_cmd(bol_pkg::CMD_REPL_LAST, 0, 32'h8000_0001, 0);
        issue_cmd(bol_pkg::CMD_REMOVE, 1, '0, 0);
        issue_cmd(bol_pkg::CMD_REMOVE, POS_MAX, '0, 0);
        issue_cmd(bol_pkg::CMD_RESIZE, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_RESIZE, 0, '0, DEPTH + 1);
        issue_cmd(bol_pkg::CMD_RESIZE, 0, '0, 2);               // shrink drops the top entry
        issue_cmd(bol_pkg::CMD_APPEND, 0, 32'h7777_7777, 0);
        issue_cmd(bol_pkg::CMD_INSERT, 0, 32'h7777_7777, 0);
        issue_cmd(bol_pkg::CMD_RESIZE, POS_MAX, '1, DEPTH);
        issue_cmd(CMD_LAST_CODE, POS_MAX, '1, POS_MAX);
        issue_cmd(CMD_UNUSED, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_CLEAR, 0, '0, 0);
        issue_cmd(bol_pkg::CMD_POP, 0, '0, 0);

        base = words_sent;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            if (ph == 0)
                fill_store();
            while (words_sent < base + (ph + 1) * PHASE_WORDS)
                run_episode();
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("bounded_ordered_list_top regression: pass");
        else
            $display("bounded_ordered_list_top regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("bounded_ordered_list_top regression: fail");
        $finish;
    end

endmodule
